>>> rtl/rlcf_pkg.sv
// rlcf_pkg: shared types, codes and byte tables for the raster line command formatter
// used by rlcf_ctrl, rlcf_dp and raster_line_command_formatter
`default_nettype none

package rlcf_pkg;

    // default row store depth in bytes
    localparam int MaxRowBytesDef = 32;
    // count fields (bytes in row, trimmed length, byte index)
    localparam int CNT_W = 6;
    // reset value of the dot threshold
    localparam logic [7:0] THRESHOLD_RST = 8'd127;

    // function codes of an input item
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_BAND  = 2'd1;
    localparam logic [1:0] FUNC_JOB   = 2'd2;

    // command stream characters
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COMMA = 8'h2c;

    // header layout: esc, g, colour, three digits, comma
    localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(6);
    localparam logic [CNT_W-1:0] BAND_LAST = CNT_W'(8);
    localparam logic [CNT_W-1:0] JOB_LAST  = CNT_W'(7);

    // header byte positions
    localparam logic [CNT_W-1:0] HDR_ESC    = CNT_W'(0);
    localparam logic [CNT_W-1:0] HDR_G      = CNT_W'(1);
    localparam logic [CNT_W-1:0] HDR_COLOUR = CNT_W'(2);
    localparam logic [CNT_W-1:0] HDR_HUND   = CNT_W'(3);
    localparam logic [CNT_W-1:0] HDR_TENS   = CNT_W'(4);
    localparam logic [CNT_W-1:0] HDR_ONES   = CNT_W'(5);

    // where the output byte comes from
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_HDR,
        SRC_DATA,
        SRC_BAND,
        SRC_JOB
    } t_src;

    // controller to datapath
    typedef struct packed {
        logic             pix_en;   // pixel item accepted
        logic             emit;     // load one byte into the output register
        t_src             src;
        logic [CNT_W-1:0] idx;      // byte index within the current source
        logic [CNT_W-1:0] rd_idx;   // row store read index for the next cycle
        logic             last;     // final byte of this item
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic             out_free; // output register can take a byte
        logic [CNT_W-1:0] cmd_len;  // trimmed byte count of the finished row
    } t_stat;

    // colour character from plane and row phase
    function automatic logic [7:0] colour_char(input logic [3:0] sel);
        logic [7:0] c;
        case (sel)
            4'd0:  c = 8'h3c;
            4'd1:  c = 8'h3d;
            4'd2:  c = 8'h3e;
            4'd3:  c = 8'h3f;
            4'd4:  c = 8'h34;
            4'd5:  c = 8'h35;
            4'd6:  c = 8'h36;
            4'd7:  c = 8'h37;
            4'd8:  c = 8'h38;
            4'd9:  c = 8'h39;
            4'd10: c = 8'h3a;
            4'd11: c = 8'h3b;
            4'd12: c = 8'h30;
            4'd13: c = 8'h31;
            4'd14: c = 8'h32;
            default: c = 8'h33;
        endcase
        return c;
    endfunction

    // band end trailer: esc k 2 esc w B esc k 1
    function automatic logic [7:0] band_byte(input logic [CNT_W-1:0] k);
        logic [7:0] c;
        case (k)
            CNT_W'(0): c = CH_ESC;
            CNT_W'(1): c = 8'h6b;
            CNT_W'(2): c = 8'h32;
            CNT_W'(3): c = CH_ESC;
            CNT_W'(4): c = 8'h77;
            CNT_W'(5): c = 8'h42;
            CNT_W'(6): c = CH_ESC;
            CNT_W'(7): c = 8'h6b;
            default:   c = 8'h31;
        endcase
        return c;
    endfunction

    // job start string: esc cr P esc w e esc backslash
    function automatic logic [7:0] job_byte(input logic [CNT_W-1:0] k);
        logic [7:0] c;
        case (k)
            CNT_W'(0): c = CH_ESC;
            CNT_W'(1): c = 8'h0d;
            CNT_W'(2): c = 8'h50;
            CNT_W'(3): c = CH_ESC;
            CNT_W'(4): c = 8'h77;
            CNT_W'(5): c = 8'h65;
            CNT_W'(6): c = CH_ESC;
            default:   c = 8'h5c;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rlcf_ctrl.sv
// rlcf_ctrl: sequencer for the formatter; accepts items and steps through header,
// row data and fixed strings; depends on rlcf_pkg
`default_nettype none

module rlcf_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_func,
    input  wire logic                 i_last_in_row,
    input  wire rlcf_pkg::t_stat      i_stat,
    output rlcf_pkg::t_cmd            o_cmd
);
    import rlcf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_SEQ
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_job, n_job;

    logic             accept;
    logic             emit;
    logic             last;
    t_src             src;
    logic [CNT_W-1:0] rd_idx;
    logic [CNT_W-1:0] idx_inc;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign emit       = (r_state != ST_IDLE) && i_stat.out_free;
    assign idx_inc    = r_idx + CNT_W'(1);

    // byte source, end of item and row store read index
    always_comb begin
        src    = SRC_NONE;
        last   = 1'b0;
        rd_idx = '0;
        case (r_state)
            ST_HDR: begin
                src  = SRC_HDR;
                last = (r_idx == HDR_LAST) && (i_stat.cmd_len == '0);
            end
            ST_DATA: begin
                src    = SRC_DATA;
                last   = (idx_inc == i_stat.cmd_len);
                rd_idx = emit ? idx_inc : r_idx;
            end
            ST_SEQ: begin
                src  = r_job ? SRC_JOB : SRC_BAND;
                last = (r_idx == (r_job ? JOB_LAST : BAND_LAST));
            end
            default: begin
                src = SRC_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_job   = r_job;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (i_func == FUNC_PIXEL && i_last_in_row) begin
                        n_state = ST_HDR;
                    end else if (i_func == FUNC_BAND) begin
                        n_state = ST_SEQ;
                        n_job   = 1'b0;
                    end else if (i_func == FUNC_JOB) begin
                        n_state = ST_SEQ;
                        n_job   = 1'b1;
                    end
                end
            end
            ST_HDR: begin
                if (emit) begin
                    if (r_idx == HDR_LAST) begin
                        n_idx   = '0;
                        n_state = last ? ST_IDLE : ST_DATA;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            ST_DATA, ST_SEQ: begin
                if (emit) begin
                    n_idx = idx_inc;
                    if (last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_job   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_job   <= n_job;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd        = '0;
        o_cmd.pix_en = accept && (i_func == FUNC_PIXEL);
        o_cmd.emit   = emit;
        o_cmd.src    = src;
        o_cmd.idx    = r_idx;
        o_cmd.rd_idx = rd_idx;
        o_cmd.last   = last;
    end

endmodule

`default_nettype wire

>>> rtl/rlcf_dp.sv
// rlcf_dp: datapath of the formatter; threshold, bit packing, row store,
// count digits and the output register; depends on rlcf_pkg
`default_nettype none

module rlcf_dp #(
    parameter int MAX_ROW_BYTES = rlcf_pkg::MaxRowBytesDef
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic [7:0]           i_pixel,
    input  wire logic [1:0]           i_plane,
    input  wire logic [1:0]           i_row_phase,
    input  wire logic                 i_last_in_row,
    input  wire logic                 i_out_stall,
    input  wire rlcf_pkg::t_cmd       i_cmd,
    output rlcf_pkg::t_stat           o_stat,
    output logic                      o_out_valid,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_byte
);
    import rlcf_pkg::*;

    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [7:0]       r_threshold;
    logic [7:0]       r_acc;
    logic [2:0]       r_pos;
    logic [CNT_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_trim;
    logic [CNT_W-1:0] r_cmd_len;
    logic [7:0]       r_colour;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic [7:0]       row_mem [MAX_ROW_BYTES];

    logic [7:0]       acc_new;
    logic [2:0]       pos_new;
    logic             wrap;
    logic             do_store;
    logic [7:0]       store_val;
    logic             wr_en;
    logic [CNT_W-1:0] bytes_inc;
    logic [CNT_W-1:0] trim_new;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic [7:0]       sel_byte;
    logic             out_free;

    // pack one thresholded pixel, store a full or padded byte
    always_comb begin
        acc_new   = {r_acc[6:0], (i_pixel > r_threshold)};
        pos_new   = r_pos + 3'd1;
        wrap      = (pos_new == 3'd0);
        do_store  = wrap || i_last_in_row;
        store_val = wrap ? acc_new : (acc_new << (3'd0 - pos_new));
        wr_en     = i_cmd.pix_en && do_store && (r_bytes < CNT_W'(MAX_ROW_BYTES));
        bytes_inc = r_bytes + CNT_W'(1);
        trim_new  = (wr_en && store_val != 8'd0) ? bytes_inc : r_trim;
    end

    // packing state and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_acc       <= '0;
            r_pos       <= '0;
            r_bytes     <= '0;
            r_trim      <= '0;
            r_cmd_len   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (i_cmd.pix_en) begin
                if (i_last_in_row) begin
                    r_cmd_len <= trim_new;
                    r_acc     <= '0;
                    r_pos     <= '0;
                    r_bytes   <= '0;
                    r_trim    <= '0;
                end else begin
                    r_acc   <= wrap ? 8'd0 : acc_new;
                    r_pos   <= pos_new;
                    r_bytes <= wr_en ? bytes_inc : r_bytes;
                    r_trim  <= trim_new;
                end
            end
        end
    end

    // colour character of the row being finished
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_en && i_last_in_row) begin
            r_colour <= colour_char({i_plane, i_row_phase});
        end
    end

    // row store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            row_mem[r_bytes[ADDR_W-1:0]] <= store_val;
        end
        r_rd_data <= row_mem[i_cmd.rd_idx[ADDR_W-1:0]];
    end

    // decimal digits of the count, which stays below one hundred
    always_comb begin
        tens = 4'd0;
        for (int k = 1; k <= 6; k++) begin
            if (r_cmd_len >= CNT_W'(k * 10)) begin
                tens = 4'(k);
            end
        end
        ones = 4'(r_cmd_len - CNT_W'(tens * 4'd10));
    end

    // output byte select
    always_comb begin
        sel_byte = 8'd0;
        case (i_cmd.src)
            SRC_HDR: begin
                case (i_cmd.idx)
                    HDR_ESC:    sel_byte = CH_ESC;
                    HDR_G:      sel_byte = CH_G;
                    HDR_COLOUR: sel_byte = r_colour;
                    HDR_HUND:   sel_byte = CH_ZERO;
                    HDR_TENS:   sel_byte = CH_ZERO + {4'd0, tens};
                    HDR_ONES:   sel_byte = CH_ZERO + {4'd0, ones};
                    default:    sel_byte = CH_COMMA;
                endcase
            end
            SRC_DATA: sel_byte = r_rd_data;
            SRC_BAND: sel_byte = band_byte(i_cmd.idx);
            SRC_JOB:  sel_byte = job_byte(i_cmd.idx);
            default:  sel_byte = 8'd0;
        endcase
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_stat.out_free = out_free;
    assign o_stat.cmd_len  = r_cmd_len;
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_byte     = r_out_last;

endmodule

`default_nettype wire

>>> rtl/raster_line_command_formatter.sv
// raster_line_command_formatter: top level joining the sequencer and the datapath
// depends on rlcf_pkg, rlcf_ctrl and rlcf_dp
//
// Pixels of one colour plane are taken one item per cycle and packed into the row
// store with no result. The item that ends a row, a band-end or a job-start item
// stalls the input while its command drains through the output register at one
// byte per cycle: 7 + N bytes for a row with N trimmed data bytes, 9 for the
// band trailer and 8 for the job start string; a stalled output holds the drain.
// The next item is taken in the cycle after the last byte is loaded. Unused function
// codes are taken and ignored. The dot threshold may be written while idle.
`default_nettype none

module raster_line_command_formatter #(
    parameter int MAX_ROW_BYTES = rlcf_pkg::MaxRowBytesDef
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_pixel,
    input  wire logic [1:0] i_plane,
    input  wire logic [1:0] i_row_phase,
    input  wire logic       i_last_in_row,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte
);
    import rlcf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    rlcf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_last_in_row (i_last_in_row),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    // datapath
    rlcf_dp #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_pixel),
        .i_plane       (i_plane),
        .i_row_phase   (i_row_phase),
        .i_last_in_row (i_last_in_row),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

`default_nettype wire

>>> bench/raster_line_command_formatter_tb.sv
// raster_line_command_formatter_tb: self-checking bench for the raster line command formatter
// depends on rlcf_pkg and raster_line_command_formatter; a scoreboard class predicts the
// command byte stream from accepted items while plain tasks drive pixels, commands and threshold
module raster_line_command_formatter_tb;
    import rlcf_pkg::*;

    localparam int         ROW_BYTES   = MaxRowBytesDef;
    // function code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       row_end;
    } t_cmd_byte;

    // predicts the printer command stream and checks it byte by byte
    class line_cmd_scoreboard;
        logic [7:0] threshold;
        logic [7:0] row_bytes [ROW_BYTES];
        logic [7:0] dot_acc;
        logic [2:0] dot_count;
        logic [5:0] bytes_held;
        logic [5:0] trim_len;
        logic [7:0] job_seq [8];
        logic [7:0] band_seq [9];
        string      colour_tbl;
        t_cmd_byte  expected_q [$];
        int         errors;

        function new();
            colour_tbl = "<=>?456789:;0123";
            job_seq    = '{CH_ESC, 8'h0d, 8'h50, CH_ESC, 8'h77, 8'h65, CH_ESC, 8'h5c};
            band_seq   = '{CH_ESC, 8'h6b, 8'h32, CH_ESC, 8'h77, 8'h42, CH_ESC, 8'h6b, 8'h31};
            threshold  = THRESHOLD_RST;
            errors     = 0;
            clear_row();
        endfunction

        function void clear_row();
            dot_acc    = 8'd0;
            dot_count  = 3'd0;
            bytes_held = 6'd0;
            trim_len   = 6'd0;
        endfunction

        function void set_threshold(input logic [7:0] v);
            threshold = v;
        endfunction

        // bytes past the store depth are dropped
        function void keep_byte(input logic [7:0] b);
            if (bytes_held < ROW_BYTES) begin
                row_bytes[bytes_held] = b;
                bytes_held = bytes_held + 6'd1;
                if (b != 8'd0) trim_len = bytes_held;
            end
        endfunction

        function void push_byte(input logic [7:0] b, input logic l);
            t_cmd_byte e;
            e.data    = b;
            e.row_end = l;
            expected_q.push_back(e);
        endfunction

        // an accepted item: update row state, queue the bytes it causes
        function void note_item(input logic [1:0] f, input logic [7:0] p,
                                input logic [1:0] pl, input logic [1:0] ph,
                                input logic l);
            int         k;
            int         cnt;
            logic [3:0] sel;
            case (f)
                FUNC_BAND: begin
                    for (k = 0; k < 9; k++) push_byte(band_seq[k], k == 8);
                end
                FUNC_JOB: begin
                    for (k = 0; k < 8; k++) push_byte(job_seq[k], k == 7);
                end
                FUNC_PIXEL: begin
                    dot_acc   = {dot_acc[6:0], p > threshold};
                    dot_count = dot_count + 3'd1;
                    if (dot_count == 3'd0) begin
                        keep_byte(dot_acc);
                        dot_acc = 8'd0;
                    end
                    if (l) begin
                        // partial byte is padded with zeros on the right
                        if (dot_count != 3'd0) keep_byte(dot_acc << (8 - dot_count));
                        cnt = trim_len;
                        sel = {pl, ph};
                        push_byte(CH_ESC, 1'b0);
                        push_byte(CH_G, 1'b0);
                        push_byte(colour_tbl[sel], 1'b0);
                        push_byte(8'(CH_ZERO + (cnt / 100) % 10), 1'b0);
                        push_byte(8'(CH_ZERO + (cnt / 10) % 10), 1'b0);
                        push_byte(8'(CH_ZERO + cnt % 10), 1'b0);
                        push_byte(CH_COMMA, cnt == 0);
                        for (k = 0; k < cnt; k++) push_byte(row_bytes[k], k == cnt - 1);
                        clear_row();
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one accepted output byte with the oldest prediction
        function void check_byte(input logic [7:0] b, input logic l);
            t_cmd_byte e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %h last %b", $time, b, l);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (b !== e.data) begin
                $display("%0t: out_byte mismatch: expected %h, actual %h", $time, e.data, b);
                errors++;
            end
            if (l !== e.row_end) begin
                $display("%0t: last_byte mismatch: expected %b, actual %b", $time, e.row_end, l);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (expected_q.size() != 0) begin
                $display("%0t: %0d bytes never arrived: expected %h, actual none", $time,
                         expected_q.size(), expected_q[0].data);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [7:0] pixel;
    logic [1:0] plane;
    logic [1:0] row_phase;
    logic       last_in_row;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_byte;

    line_cmd_scoreboard sb;
    int                 cur_thr;
    int                 items_sent;
    int                 bytes_seen;
    int                 burst_left;

    raster_line_command_formatter #(
        .MAX_ROW_BYTES(ROW_BYTES)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (func),
        .i_pixel      (pixel),
        .i_plane      (plane),
        .i_row_phase  (row_phase),
        .i_last_in_row(last_in_row),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_byte),
        .o_last_byte  (last_byte)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle cycles before the next item: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until taken
    task automatic send_item(input logic [1:0] f, input logic [7:0] p,
                             input logic [1:0] pl, input logic [1:0] ph, input logic l);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        func        = f;
        pixel       = p;
        plane       = pl;
        row_phase   = ph;
        last_in_row = l;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(f, p, pl, ph, l);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // threshold changes only once the block is idle
    task automatic write_threshold(input logic [7:0] v);
        stop_sending();
        wait_drained();
        repeat (12) @(negedge clk);
        cfg_data = v;
        cfg_we   = 1'b1;
        @(posedge clk);
        sb.set_threshold(v);
        cur_thr = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // band end, job start or an ignored code, with random other fields
    task automatic send_command();
        logic [1:0] f;
        case ($urandom_range(0, 2))
            0:       f = FUNC_BAND;
            1:       f = FUNC_JOB;
            default: f = FUNC_UNUSED;
        endcase
        send_item(f, 8'($urandom), 2'($urandom), 2'($urandom), 1'($urandom));
    endtask

    // one row with random dot density, sometimes a blank tail, stray commands mixed in
    task automatic send_row(input logic [1:0] pl, input logic [1:0] ph, input int len);
        int         k;
        int         dens;
        int         cut;
        logic [7:0] p;
        dens = $urandom_range(0, 100);
        cut  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 4) send_command();
            if (k < cut && $urandom_range(1, 100) <= dens && cur_thr < 255)
                p = 8'($urandom_range(cur_thr + 1, 255));
            else
                p = 8'($urandom_range(0, cur_thr));
            send_item(FUNC_PIXEL, p, pl, ph, k == len - 1);
        end
    endtask

    // rows until about n items went in; the first row may overrun the row store
    task automatic random_rows(input int n, input bit force_long);
        int start;
        int rows;
        int len;
        start = items_sent;
        rows  = 0;
        while (items_sent - start < n) begin
            if (force_long && rows == 0)
                len = $urandom_range(260, 280);
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(1, 48);
            send_row(2'($urandom), 2'($urandom), len);
            rows++;
        end
    endtask

    // output side: check accepted bytes, stall at random, one long hold-off
    initial begin
        int hold;
        bit pressure_done;
        out_stall     = 1'b0;
        hold          = 0;
        pressure_done = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_byte(out_byte, last_byte);
                bytes_seen++;
            end
            @(negedge clk);
            if (!pressure_done && bytes_seen >= 60) begin
                pressure_done = 1;
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                out_stall = 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (out_stall) begin
                out_stall = 1'b0;
                hold = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
            end else begin
                out_stall = 1'b1;
                hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 30);
            end
        end
    end

    // run limit
    initial begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

    // stimulus
    initial begin
        int k;
        sb          = new();
        cur_thr     = THRESHOLD_RST;
        items_sent  = 0;
        bytes_seen  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 8'd0;
        in_valid    = 1'b0;
        func        = FUNC_PIXEL;
        pixel       = 8'd0;
        plane       = 2'd0;
        row_phase   = 2'd0;
        last_in_row = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: job start, threshold edges, all-zero row, exact byte
        send_item(FUNC_JOB, 8'd0, 2'd0, 2'd0, 1'b0);
        send_item(FUNC_PIXEL, 8'd128, 2'd0, 2'd0, 1'b1);
        send_item(FUNC_PIXEL, 8'd127, 2'd3, 2'd3, 1'b1);
        for (k = 0; k < 8; k++)
            send_item(FUNC_PIXEL, (k % 2 == 0) ? 8'd255 : 8'd0, 2'd1, 2'd1, k == 7);
        // commands in mid-row keep the partial row; ignored code even with last set
        send_item(FUNC_PIXEL, 8'd255, 2'd2, 2'd2, 1'b0);
        send_item(FUNC_UNUSED, 8'd255, 2'd3, 2'd3, 1'b1);
        send_item(FUNC_BAND, 8'd0, 2'd0, 2'd0, 1'b0);
        send_item(FUNC_PIXEL, 8'd0, 2'd2, 2'd2, 1'b0);
        send_item(FUNC_JOB, 8'd0, 2'd0, 2'd0, 1'b0);
        send_item(FUNC_PIXEL, 8'd200, 2'd2, 2'd2, 1'b1);
        // leading zero byte is kept, padded partial byte follows
        for (k = 0; k < 9; k++)
            send_item(FUNC_PIXEL, (k == 8) ? 8'd255 : 8'd0, 2'd1, 2'd2, k == 8);
        send_item(FUNC_BAND, 8'd0, 2'd0, 2'd0, 1'b0);

        // one overlong row, then random rows under several thresholds
        random_rows(1, 1);
        random_rows(25, 0);
        write_threshold(8'd0);
        random_rows(20, 0);
        write_threshold(8'd255);
        random_rows(20, 0);
        write_threshold(8'($urandom_range(1, 254)));
        random_rows(30, 0);
        stop_sending();

        // drain and let the block settle
        wait_drained();
        repeat (40) @(posedge clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
